// ===== rtl/core/oaht_pkg.sv =====
// types and constants for the open-address hash table
// no dependencies
package oaht_pkg;
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [1:0] MARK_EMPTY    = 2'd0;
   localparam logic [1:0] MARK_OCCUPIED = 2'd1;
   localparam logic [1:0] MARK_DELETED  = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam int SIZE_W = 11;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  slot;
      logic [10:0] probes;
      logic [31:0] found_value;
      logic [10:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mod_ctl_type;
endpackage

// ===== rtl/core/oaht_req_if.sv =====
// request channel interface
// depends on oaht_pkg
interface oaht_req_if import oaht_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/oaht_rsp_if.sv =====
// response channel interface
// depends on oaht_pkg
interface oaht_rsp_if import oaht_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/oaht_mod.sv =====
// restoring remainder unit: one quotient bit per cycle
// depends on oaht_pkg
module oaht_mod import oaht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [SIZE_W-1:0] divisor,
   output mod_ctl_type       ctl,
   output logic [SIZE_W-1:0] remainder
);
   logic [31:0]       quo_ff, quo_in;
   logic [SIZE_W:0]   rem_ff, rem_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[SIZE_W-1:0], quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            rem_in = shifted - {1'b0, divisor};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign remainder = rem_ff[SIZE_W-1:0];
endmodule

// ===== rtl/core/open_address_hash_table.sv =====
// open-address hash table top level: sequencer, slot memories, remainder unit
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_mod
//
// channel  dir  payload                                  handshake
// req      in   action, key, value                       valid/ready
// rsp      out  status, slot, probes, found_value, count valid/ready
// csr      in   table_size                               write enable
//
// an item is taken while idle; its home slot is the key magnitude modulo
// table_size (one bit a cycle in the remainder unit); for insert, remove and
// search, slots are read and evaluated in turn; the result goes to out_ff.
// a clearing pass over all TABLE_DEPTH slots runs after reset and after every
// table_size write; no item is taken meanwhile.
// ready stays low while an item is in work; a finished item waits in its last
// state while the output register still holds an untaken result.
module open_address_hash_table import oaht_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   oaht_req_if.sink          req,
   oaht_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [SIZE_W-1:0] csr_write_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = AW + 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [1:0]  mark_mem  [TABLE_DEPTH];
   logic [31:0] key_mem   [TABLE_DEPTH];
   logic [31:0] value_mem [TABLE_DEPTH];

   logic [2:0]        state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     attempt_ff, attempt_in;
   req_type           item_ff, item_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        rd_mark;
   logic [31:0]       rd_key, rd_value;

   logic              mark_we, kv_we, val_we;
   logic [1:0]        mark_wd;
   logic [31:0]       mag;
   logic              mod_start;
   mod_ctl_type       mod_ctl;
   logic [SIZE_W-1:0] mod_rem;
   logic [SIZE_W-1:0] size_clamped;
   logic [AW-1:0]     next_ptr;
   logic [CW-1:0]     size_cw;
   logic              key_hit;

   always_comb begin
      if (csr_write_data == '0) begin
         size_clamped = SIZE_W'(1);
      end else if (32'(csr_write_data) > 32'(TABLE_DEPTH)) begin
         size_clamped = SIZE_W'(TABLE_DEPTH);
      end else begin
         size_clamped = csr_write_data;
      end
   end

   assign mag       = item_ff.key[31] ? (32'd0 - item_ff.key) : item_ff.key;
   assign size_cw   = CW'(size_ff);
   assign next_ptr  = (ptr_ff == '0) ? AW'(size_ff - SIZE_W'(1)) : ptr_ff - AW'(1);
   assign key_hit   = (rd_mark == MARK_OCCUPIED) && (rd_key == item_ff.key);

   oaht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mag),
      .divisor   (size_ff),
      .ctl       (mod_ctl),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      rd_mark  <= mark_mem[ptr_ff];
      rd_key   <= key_mem[ptr_ff];
      rd_value <= value_mem[ptr_ff];
      if (mark_we) begin
         mark_mem[ptr_ff] <= mark_wd;
      end
      if (kv_we) begin
         key_mem[ptr_ff] <= item_ff.key;
      end
      if (val_we) begin
         value_mem[ptr_ff] <= item_ff.value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      attempt_in   = attempt_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      mark_we      = 1'b0;
      kv_we        = 1'b0;
      val_we       = 1'b0;
      mark_wd      = MARK_EMPTY;
      mod_start    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mark_we = 1'b1;
            if (32'(ptr_ff) == TABLE_DEPTH - 1) begin
               state_in = S_IDLE;
               ptr_in   = '0;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               item_in  = req.payload;
               state_in = S_HASH;
               mod_start = 1'b0;
            end
         end
         S_HASH: begin
            if (!mod_ctl.busy && !mod_ctl.done) begin
               mod_start = 1'b1;
            end
            if (mod_ctl.done) begin
               ptr_in     = AW'(mod_rem);
               attempt_in = '0;
               res_in     = '0;
               res_in.status = ST_NOT_FOUND;
               if (item_ff.action == ACT_INSERT || item_ff.action == ACT_REMOVE ||
                   item_ff.action == ACT_SEARCH) begin
                  state_in = S_READ;
               end else begin
                  res_in.entry_count = SIZE_W'(count_ff);
                  state_in = S_RESP;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            res_in.entry_count = SIZE_W'(count_ff);
            if (item_ff.action == ACT_INSERT) begin
               if (rd_mark == MARK_OCCUPIED && !key_hit) begin
                  attempt_in = attempt_ff + CW'(1);
                  ptr_in     = next_ptr;
                  state_in   = S_READ;
                  if (attempt_ff + CW'(1) >= size_cw) begin
                     res_in.status = ST_FULL;
                     res_in.probes = SIZE_W'(attempt_ff + CW'(1));
                     state_in      = S_RESP;
                  end
               end else if (key_hit) begin
                  val_we        = 1'b1;
                  res_in.status = ST_UPDATED;
                  res_in.slot   = 10'(ptr_ff);
                  res_in.probes = SIZE_W'(attempt_ff);
                  state_in      = S_RESP;
               end else begin
                  mark_we  = 1'b1;
                  mark_wd  = MARK_OCCUPIED;
                  kv_we    = 1'b1;
                  val_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  res_in.entry_count = SIZE_W'(count_ff + CW'(1));
                  res_in.status = ST_INSERTED;
                  res_in.slot   = 10'(ptr_ff);
                  res_in.probes = SIZE_W'(attempt_ff);
                  state_in      = S_RESP;
               end
            end else begin
               res_in.probes = SIZE_W'(attempt_ff);
               if (rd_mark == MARK_EMPTY || attempt_ff >= size_cw) begin
                  state_in = S_RESP;
               end else if (key_hit) begin
                  res_in.slot = 10'(ptr_ff);
                  if (item_ff.action == ACT_REMOVE) begin
                     mark_we = 1'b1;
                     mark_wd = MARK_DELETED;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                        res_in.entry_count = SIZE_W'(count_ff - CW'(1));
                     end
                     res_in.status = ST_REMOVED;
                  end else begin
                     res_in.status      = ST_FOUND;
                     res_in.found_value = rd_value;
                  end
                  state_in = S_RESP;
               end else begin
                  attempt_in = attempt_ff + CW'(1);
                  ptr_in     = next_ptr;
                  state_in   = S_READ;
                  if (attempt_ff + CW'(1) >= size_cw) begin
                     res_in.probes = SIZE_W'(attempt_ff + CW'(1));
                     state_in      = S_RESP;
                  end
               end
            end
         end
         S_RESP: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         size_in  = size_clamped;
         count_in = '0;
         ptr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      attempt_ff <= attempt_in;
      item_ff    <= item_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= SIZE_W'(TABLE_DEPTH > 1024 ? 1024 : TABLE_DEPTH);
         count_ff     <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule

// ===== sim/testbench.sv =====
// regression bench for open_address_hash_table: directed cases then random traffic
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if and the block itself
module testbench;
   import oaht_pkg::*;

   localparam int DEPTH = 1024;
   localparam int DIRECTED_N = 20;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [SIZE_W-1:0] csr_write_data;

   oaht_req_if req ();
   oaht_rsp_if rsp ();

   open_address_hash_table #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // shadow copy of the table
   logic [1:0]  shadow_mark [DEPTH];
   logic [31:0] shadow_key [DEPTH];
   logic [31:0] shadow_value [DEPTH];
   int unsigned shadow_count;
   int unsigned active_size;

   rsp_type pending_rsp [$];
   int fail_count;
   bit hold_rsp;
   bit random_stall;

   // directed stimulus; check_now marks rows whose result is typed in
   typedef struct {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] value;
      bit          check_now;
      rsp_type     result;
   } step_row;

   step_row directed [DIRECTED_N];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #80000000;
      $display("open_address_hash_table regression: fail");
      $finish;
   end

   function automatic void clear_shadow(input int unsigned size_word);
      size_word = size_word & 11'h7ff;
      if (size_word == 0) active_size = 1;
      else if (size_word > DEPTH) active_size = DEPTH;
      else active_size = size_word;
      for (int i = 0; i < DEPTH; i++) shadow_mark[i] = MARK_EMPTY;
      shadow_count = 0;
   endfunction

   function automatic rsp_type table_lookup(input req_type item);
      rsp_type r;
      logic [31:0] magnitude;
      int unsigned s;
      int unsigned attempt;
      bit full;
      magnitude = item.key[31] ? (32'd0 - item.key) : item.key;
      s = magnitude % active_size;
      attempt = 0;
      full = 1'b0;
      r.status = ST_NOT_FOUND;
      r.slot = '0;
      r.found_value = '0;
      if (item.action == ACT_INSERT) begin
         while (shadow_mark[s] == MARK_OCCUPIED && shadow_key[s] != item.key) begin
            attempt++;
            s = (s == 0) ? active_size - 1 : s - 1;
            if (attempt >= active_size) begin
               full = 1'b1;
               break;
            end
         end
         if (full) begin
            r.status = ST_FULL;
         end else if (shadow_mark[s] == MARK_OCCUPIED) begin
            shadow_value[s] = item.value;
            r.status = ST_UPDATED;
            r.slot = s[9:0];
         end else begin
            shadow_key[s] = item.key;
            shadow_value[s] = item.value;
            shadow_mark[s] = MARK_OCCUPIED;
            shadow_count++;
            r.status = ST_INSERTED;
            r.slot = s[9:0];
         end
      end else if (item.action == ACT_REMOVE || item.action == ACT_SEARCH) begin
         while (shadow_mark[s] != MARK_EMPTY && attempt < active_size) begin
            if (shadow_mark[s] == MARK_OCCUPIED && shadow_key[s] == item.key) begin
               r.slot = s[9:0];
               if (item.action == ACT_REMOVE) begin
                  shadow_mark[s] = MARK_DELETED;
                  if (shadow_count > 0) shadow_count--;
                  r.status = ST_REMOVED;
               end else begin
                  r.found_value = shadow_value[s];
                  r.status = ST_FOUND;
               end
               break;
            end
            attempt++;
            s = (s == 0) ? active_size - 1 : s - 1;
         end
      end
      r.probes = attempt[10:0];
      r.entry_count = shadow_count[10:0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] st, input int unsigned sl,
                                        input int unsigned pr, input logic [31:0] fv,
                                        input int unsigned cnt);
      rsp_type r;
      r.status = st;
      r.slot = sl[9:0];
      r.probes = pr[10:0];
      r.found_value = fv;
      r.entry_count = cnt[10:0];
      return r;
   endfunction

   task automatic send_item(input req_type item, input bit check_now, input rsp_type typed);
      rsp_type predicted;
      req.valid <= 1'b1;
      req.payload <= item;
      do @(posedge clock); while (!req.ready);
      predicted = table_lookup(item);
      if (check_now && predicted != typed) begin
         $error("typed result %p disagrees with prediction %p", typed, predicted);
         fail_count++;
      end
      pending_rsp.push_back(predicted);
   endtask

   task automatic offer_item(input req_type item);
      send_item(item, 1'b0, '0);
   endtask

   task automatic idle_cycles(input int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_size(input int unsigned size_word);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= size_word[SIZE_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      clear_shadow(size_word);
   endtask

   function automatic logic [31:0] pick_key(input int unsigned size_now);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0001;
         4: return -($urandom_range(0, 3 * size_now));
         default: return $urandom_range(0, 3 * size_now);
      endcase
   endfunction

   function automatic req_type random_item(input int unsigned size_now);
      req_type item;
      int pick;
      pick = $urandom_range(0, 99);
      item.action = pick < 45 ? ACT_INSERT : pick < 65 ? ACT_REMOVE :
                    pick < 97 ? ACT_SEARCH : ACT_UNUSED;
      item.key = pick_key(size_now);
      item.value = $urandom();
      return item;
   endfunction

   task automatic random_phase(input int unsigned size_word, input int n_items);
      int burst;
      int sent;
      write_size(size_word);
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < n_items; i++) begin
            offer_item(random_item(active_size));
            sent++;
         end
         if (sent < n_items && $urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 80));
      end
   endtask

   initial begin
      int unsigned sizes [6];
      int counts [6];
      directed[0]  = '{ACT_SEARCH, 32'd5, 32'd0, 1, make_rsp(ST_NOT_FOUND, 0, 0, 0, 0)};
      directed[1]  = '{ACT_INSERT, 32'd0, 32'hffff_ffff, 1, make_rsp(ST_INSERTED, 0, 0, 0, 1)};
      directed[2]  = '{ACT_SEARCH, 32'd0, 32'd0, 1,
                       make_rsp(ST_FOUND, 0, 0, 32'hffff_ffff, 1)};
      directed[3]  = '{ACT_INSERT, 32'd0, 32'h0, 1, make_rsp(ST_UPDATED, 0, 0, 0, 1)};
      directed[4]  = '{ACT_INSERT, 32'h8000_0000, 32'h1234_5678, 0, '0};
      directed[5]  = '{ACT_INSERT, 32'h7fff_ffff, 32'ha5a5_a5a5, 0, '0};
      directed[6]  = '{ACT_INSERT, 32'h8000_0001, 32'h5a5a_5a5a, 0, '0};
      directed[7]  = '{ACT_INSERT, 32'd1024, 32'd7, 0, '0};
      directed[8]  = '{ACT_INSERT, 32'd2048, 32'd8, 0, '0};
      directed[9]  = '{ACT_REMOVE, 32'd1024, 32'd0, 0, '0};
      directed[10] = '{ACT_INSERT, 32'd2048, 32'd9, 0, '0};
      directed[11] = '{ACT_SEARCH, 32'd2048, 32'd0, 0, '0};
      directed[12] = '{ACT_UNUSED, 32'd0, 32'hdead_beef, 1,
                       make_rsp(ST_NOT_FOUND, 0, 0, 0, 0)};
      directed[13] = '{ACT_SEARCH, 32'h8000_0000, 32'd0, 0, '0};
      directed[14] = '{ACT_REMOVE, 32'h7fff_ffff, 32'd0, 0, '0};
      directed[15] = '{ACT_REMOVE, 32'd3072, 32'd0, 0, '0};
      directed[16] = '{ACT_SEARCH, 32'hffff_fffb, 32'd0, 0, '0};
      directed[17] = '{ACT_INSERT, 32'hffff_fffb, 32'd3, 0, '0};
      directed[18] = '{ACT_SEARCH, 32'd5, 32'd0, 0, '0};
      directed[19] = '{ACT_REMOVE, 32'd0, 32'd0, 0, '0};
      // the unused-action row expects the count left by the rows above it
      directed[12].result.entry_count = 11'd6;

      fail_count = 0;
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      clear_shadow(1024);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++)
         send_item('{directed[i].action, directed[i].key, directed[i].value},
                   directed[i].check_now, directed[i].result);

      // size one: fill, then full and chain cases
      write_size(0);
      offer_item('{ACT_INSERT, 32'd9, 32'd1});
      offer_item('{ACT_INSERT, 32'd10, 32'd2});
      offer_item('{ACT_SEARCH, 32'd10, 32'd0});
      offer_item('{ACT_REMOVE, 32'd9, 32'd0});
      offer_item('{ACT_INSERT, 32'd10, 32'd3});
      offer_item('{ACT_SEARCH, 32'hffff_fff7, 32'd0});

      // receiver holds off while the sender keeps offering
      write_size(8);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) offer_item(random_item(8));
      join

      sizes = '{2047, 3, 16, 7, 1024, 61};
      counts = '{40, 250, 400, 300, 350, 330};
      for (int p = 0; p < 6; p++) random_phase(sizes[p], counts[p]);

      wait_drained();
      if (fail_count == 0) begin
         $display("open_address_hash_table regression: pass");
      end else begin
         $display("open_address_hash_table regression: fail");
      end
      $finish;
   end

   initial begin
      rsp.ready <= 1'b0;
      random_stall = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 15) == 0) random_stall = ~random_stall;
         rsp.ready <= !hold_rsp && !(random_stall && $urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result arrived with nothing expected");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp.payload.status);
               fail_count++;
            end
            if (rsp.payload.slot !== want.slot) begin
               $error("slot expected %0d actual %0d", want.slot, rsp.payload.slot);
               fail_count++;
            end
            if (rsp.payload.probes !== want.probes) begin
               $error("probes expected %0d actual %0d", want.probes, rsp.payload.probes);
               fail_count++;
            end
            if (rsp.payload.found_value !== want.found_value) begin
               $error("found_value expected %h actual %h", want.found_value,
                      rsp.payload.found_value);
               fail_count++;
            end
            if (rsp.payload.entry_count !== want.entry_count) begin
               $error("entry_count expected %0d actual %0d", want.entry_count,
                      rsp.payload.entry_count);
               fail_count++;
            end
         end
      end
   end
endmodule
